@@ rtl/mhpq_pkg.sv @@
`timescale 1ns / 1ps

package mhpq_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 11;
  localparam int ERR_W     = 2;

  // Operation kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  // Datapath commands
  localparam int CMD_W = 4;
  localparam logic [CMD_W-1:0] CMD_IDLE      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_INIT = 4'd1;
  localparam logic [CMD_W-1:0] CMD_POP_INIT  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_LOAD_LAST = 4'd3;
  localparam logic [CMD_W-1:0] CMD_UP_READ   = 4'd4;
  localparam logic [CMD_W-1:0] CMD_UP_STEP   = 4'd5;
  localparam logic [CMD_W-1:0] CMD_DOWN_READ = 4'd6;
  localparam logic [CMD_W-1:0] CMD_DOWN_STEP = 4'd7;
  localparam logic [CMD_W-1:0] CMD_PLACE     = 4'd8;
  localparam logic [CMD_W-1:0] CMD_REPORT    = 4'd9;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic [ERR_W-1:0] err;
  } cmd_t;

  typedef struct packed {
    logic node_gt1;   // sift-up node is below the root
    logic parent_gt;  // parent larger than the moving value
    logic has_child;  // sift-down node has at least one child
    logic down_move;  // smaller child is below the moving value
    logic empty;
    logic full;
  } sts_t;

endpackage

@@ rtl/mhpq_ctrl.sv @@
`timescale 1ns / 1ps

module mhpq_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          kind,
  output logic          out_valid,
  input  logic          out_ready,
  input  mhpq_pkg::sts_t sts,
  output mhpq_pkg::cmd_t cmd
);
  import mhpq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_CHK = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_LOAD   = 3'd3;
  localparam logic [2:0] S_DN_CHK = 3'd4;
  localparam logic [2:0] S_DN_CMP = 3'd5;
  localparam logic [2:0] S_REPORT = 3'd6;

  logic [2:0]       state, state_next;
  logic [ERR_W-1:0] err_reg, err_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    err_next   = err_reg;
    cmd.op     = CMD_IDLE;
    cmd.err    = err_reg;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (kind == KIND_PUSH) begin
            if (sts.full) begin
              err_next   = ERR_FULL;
              state_next = S_REPORT;
            end else begin
              err_next   = ERR_NONE;
              cmd.op     = CMD_PUSH_INIT;
              state_next = S_UP_CHK;
            end
          end else begin
            if (sts.empty) begin
              err_next   = ERR_EMPTY;
              state_next = S_REPORT;
            end else begin
              err_next   = ERR_NONE;
              cmd.op     = CMD_POP_INIT;
              state_next = S_LOAD;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (sts.node_gt1) begin
          cmd.op     = CMD_UP_READ;
          state_next = S_UP_CMP;
        end else begin
          cmd.op     = CMD_PLACE;
          state_next = S_REPORT;
        end
      end
      S_UP_CMP: begin
        cmd.op     = CMD_UP_STEP;
        state_next = sts.parent_gt ? S_UP_CHK : S_REPORT;
      end
      S_LOAD: begin
        cmd.op     = CMD_LOAD_LAST;
        state_next = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (sts.has_child) begin
          cmd.op     = CMD_DOWN_READ;
          state_next = S_DN_CMP;
        end else begin
          cmd.op     = CMD_PLACE;
          state_next = S_REPORT;
        end
      end
      S_DN_CMP: begin
        cmd.op     = CMD_DOWN_STEP;
        state_next = sts.down_move ? S_DN_CHK : S_REPORT;
      end
      S_REPORT: begin
        if (!out_valid || out_ready) begin
          cmd.op     = CMD_REPORT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      err_reg   <= ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      err_reg <= err_next;
      if (cmd.op == CMD_REPORT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat accepted while an operation is in flight");

  a_report_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_REPORT) |-> (!out_valid || out_ready))
    else $error("result loaded over an untaken beat");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped before it was taken");
`endif

endmodule

@@ rtl/mhpq_dp.sv @@
`timescale 1ns / 1ps

module mhpq_dp #(
  parameter int DEPTH = mhpq_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mhpq_pkg::cmd_t                       cmd,
  input  logic signed [mhpq_pkg::DATA_W-1:0]   value,
  output mhpq_pkg::sts_t                       sts,
  output logic signed [mhpq_pkg::DATA_W-1:0]   top_value,
  output logic                                 is_empty,
  output logic [mhpq_pkg::COUNT_W-1:0]         count,
  output logic [mhpq_pkg::ERR_W-1:0]           error
);
  import mhpq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);  // one-based node index / count
  localparam int AW = $clog2(DEPTH);      // zero-based memory address

  logic signed [DATA_W-1:0] mem [DEPTH];

  logic [CW-1:0]            cnt;
  logic [CW-1:0]            node;
  logic [CW:0]              child;
  logic signed [DATA_W-1:0] val;
  logic signed [DATA_W-1:0] root;
  logic signed [DATA_W-1:0] rdata_a, rdata_b;

  logic [AW-1:0]            raddr_a, raddr_b, waddr;
  logic                     we;
  logic signed [DATA_W-1:0] wdata;
  logic                     child_lt_cnt;
  logic                     sel_b;
  logic signed [DATA_W-1:0] minv;
  logic [CW:0]              mchild;

  // smaller child pick; right child only when it exists
  assign child_lt_cnt = (child < {1'b0, cnt});
  assign sel_b        = child_lt_cnt && (rdata_b < rdata_a);
  assign minv         = sel_b ? rdata_b : rdata_a;
  assign mchild       = child + (CW+1)'(sel_b);

  assign sts.node_gt1  = (node > CW'(1));
  assign sts.parent_gt = (rdata_a > val);
  assign sts.has_child = (child <= {1'b0, cnt});
  assign sts.down_move = (minv < val);
  assign sts.empty     = (cnt == '0);
  assign sts.full      = (cnt >= CW'(DEPTH));

  assign waddr = AW'(node - CW'(1));

  always_comb begin
    raddr_a = '0;
    raddr_b = '0;
    we      = 1'b0;
    wdata   = val;
    unique case (cmd.op)
      CMD_POP_INIT: begin
        raddr_a = AW'(cnt - CW'(1));
      end
      CMD_UP_READ: begin
        raddr_a = AW'((node >> 1) - CW'(1));
      end
      CMD_DOWN_READ: begin
        raddr_a = AW'(child - (CW+1)'(1));
        raddr_b = child_lt_cnt ? AW'(child) : '0;
      end
      CMD_UP_STEP: begin
        we    = 1'b1;
        wdata = sts.parent_gt ? rdata_a : val;
      end
      CMD_DOWN_STEP: begin
        we    = 1'b1;
        wdata = sts.down_move ? minv : val;
      end
      CMD_PLACE: begin
        we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case (cmd.op)
        CMD_PUSH_INIT: cnt <= cnt + CW'(1);
        CMD_POP_INIT:  cnt <= cnt - CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we && (node == CW'(1))) begin
      root <= wdata;
    end
    case (cmd.op)
      CMD_PUSH_INIT: begin
        val  <= value;
        node <= cnt + CW'(1);
      end
      CMD_POP_INIT: begin
        node  <= CW'(1);
        child <= (CW+1)'(2);
      end
      CMD_LOAD_LAST: begin
        val <= rdata_a;
      end
      CMD_UP_STEP: begin
        if (sts.parent_gt) begin
          node <= node >> 1;
        end
      end
      CMD_DOWN_STEP: begin
        if (sts.down_move) begin
          node  <= mchild[CW-1:0];
          child <= {mchild[CW-1:0], 1'b0};
        end
      end
      CMD_REPORT: begin
        top_value <= sts.empty ? '0 : root;
        is_empty  <= sts.empty;
        count     <= COUNT_W'(cnt);
        error     <= cmd.err;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("element count above capacity");

  // popping the only element still places it in the root slot
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> ((node != '0) && ((node <= cnt) || (node == CW'(1)))))
    else $error("heap write outside the live slots");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == CMD_PUSH_INIT) |=> (cnt == $past(cnt) + CW'(1)))
    else $error("push did not grow the count");
`endif

endmodule

@@ rtl/min_heap_priority_queue_top.sv @@
// Min-heap priority queue: push sifts up, pop sifts the last element down.
// One operation at a time; errors skip the sift and go straight to the result. The
// next beat is taken the cycle after the result loads; each tree level costs a read
// and a compare step.
// Sync reset empties the heap; no memory clear.
`timescale 1ns / 1ps

module min_heap_priority_queue_top #(
  parameter int DEPTH = mhpq_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input beats
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                kind,
  input  logic signed [mhpq_pkg::DATA_W-1:0]  value,
  // result beats
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mhpq_pkg::DATA_W-1:0]  top_value,
  output logic                                is_empty,
  output logic [mhpq_pkg::COUNT_W-1:0]        count,
  output logic [mhpq_pkg::ERR_W-1:0]          error
);
  import mhpq_pkg::*;

  cmd_t cmd;   // controller -> datapath
  sts_t sts;   // datapath -> controller

  // Sequencer: decodes push/pop, walks the sift loop, holds the result
  // beat handshake.
  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Heap memory (two read ports, one write port), count, root copy,
  // comparators and the result register.
  mhpq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .sts       (sts),
    .top_value (top_value),
    .is_empty  (is_empty),
    .count     (count),
    .error     (error)
  );

endmodule

@@ dv/min_heap_priority_queue_top_tb.sv @@
`timescale 1ns / 1ps

module min_heap_priority_queue_top_tb;
  import mhpq_pkg::*;

  localparam int HEAP_DEPTH   = DEPTH_DEF;
  localparam int WATCHDOG     = 3000;  // idle cycles before the run is declared hung
  localparam int HOLD_AT      = 150;   // result beats seen before the long back-pressure
  localparam int HOLD_CYCLES  = 500;   // long receiver hold-off, well under WATCHDOG
  localparam int DRAIN_CYCLES = 40;    // quiet time after the last result beat; longer than the worst pop, with margin
  localparam int RANDOM_TOTAL = 1875;  // directed + random beats queued

  // one operation beat as queued for the driver
  typedef struct packed {
    logic                     op_kind;
    logic signed [DATA_W-1:0] op_value;
  } heap_op_t;

  // one predicted result beat
  typedef struct packed {
    logic signed [DATA_W-1:0] top;
    logic                     empty;
    logic [COUNT_W-1:0]       cnt;
    logic [ERR_W-1:0]         err;
  } heap_report_t;

  logic                     clk       = 1'b0;
  logic                     rst       = 1'b1;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  logic                     kind      = KIND_PUSH;
  logic signed [DATA_W-1:0] value     = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] top_value;
  logic                     is_empty;
  logic [COUNT_W-1:0]       count;
  logic [ERR_W-1:0]         error;

  min_heap_priority_queue_top #(
    .DEPTH(HEAP_DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind),
    .value    (value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .top_value(top_value),
    .is_empty (is_empty),
    .count    (count),
    .error    (error)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow heap: one-based array, same sift rules as the block.
  // Only slots 1..heap_size are ever read, so unwritten slots never matter.
  // ---------------------------------------------------------------------------
  logic signed [DATA_W-1:0] heap_slots [1:HEAP_DEPTH];
  int unsigned              heap_size = 0;

  // run statistics for the closing summary
  int unsigned push_total  = 0;
  int unsigned pop_total   = 0;
  int unsigned empty_pops  = 0;
  int unsigned full_pushes = 0;
  int unsigned peak_size   = 0;
  int unsigned fail_count  = 0;

  heap_op_t     pending_ops [$];       // beats not yet handed to the driver
  heap_report_t expected_reports [$];  // predictions waiting for their result beat

  // Apply one operation to the shadow heap and return the result it must report.
  function automatic heap_report_t heap_apply(logic op_kind, logic signed [DATA_W-1:0] v);
    heap_report_t             rpt;
    logic signed [DATA_W-1:0] last;
    int unsigned              node;
    int unsigned              child;
    logic                     settled;
    rpt.err = ERR_NONE;
    if (op_kind == KIND_PUSH) begin
      push_total++;
      if (heap_size >= HEAP_DEPTH) begin
        rpt.err = ERR_FULL;
        full_pushes++;
      end else begin
        // sift up past every strictly larger parent
        heap_size++;
        node = heap_size;
        while (node > 1 && heap_slots[node / 2] > v) begin
          heap_slots[node] = heap_slots[node / 2];
          node = node / 2;
        end
        heap_slots[node] = v;
      end
    end else begin
      pop_total++;
      if (heap_size == 0) begin
        rpt.err = ERR_EMPTY;
        empty_pops++;
      end else begin
        // old last element sifts down along the smaller child; ties stop it
        last    = heap_slots[heap_size];
        node    = 1;
        child   = 2;
        settled = 1'b0;
        heap_size--;
        while (!settled && child <= heap_size) begin
          if (child < heap_size && heap_slots[child] > heap_slots[child + 1])
            child++;
          if (last <= heap_slots[child]) begin
            settled = 1'b1;
          end else begin
            heap_slots[node] = heap_slots[child];
            node  = child;
            child = child * 2;
          end
        end
        heap_slots[node] = last;
      end
    end
    if (heap_size > peak_size)
      peak_size = heap_size;
    rpt.top   = (heap_size > 0) ? heap_slots[1] : '0;
    rpt.empty = (heap_size == 0);
    rpt.cnt   = heap_size[COUNT_W-1:0];
    return rpt;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers. gen_size tracks occupancy at generation time; it only
  // depends on the op sequence, so phases can steer toward empty or full.
  // ---------------------------------------------------------------------------
  int unsigned gen_size = 0;

  // mostly short gaps, some medium, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // full-range values flip every bit; narrow bands force ties in the sifts
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = int'($urandom_range(0, 16)) - 8;
      7: begin
        case ($urandom_range(0, 4))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = '0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
      default:    v = int'($urandom_range(0, 2000)) - 1000;
    endcase
    return v;
  endfunction

  task automatic queue_op(logic op_kind, logic signed [DATA_W-1:0] v);
    heap_op_t op;
    op.op_kind  = op_kind;
    op.op_value = v;
    if (op_kind == KIND_PUSH && gen_size < HEAP_DEPTH) gen_size++;
    if (op_kind == KIND_POP && gen_size > 0) gen_size--;
    pending_ops.push_back(op);
  endtask

  task automatic queue_random(int unsigned push_pct);
    queue_op(($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP, pick_value());
  endtask

  // ---------------------------------------------------------------------------
  // Driver: hands queued beats to the block, with random gaps between beats
  // and occasional bursts with no gaps at all.
  // ---------------------------------------------------------------------------
  int unsigned send_gap   = 0;
  logic        send_burst = 1'b0;

  always @(posedge clk) begin : send_side
    heap_op_t op;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      // current beat (if any) is taken this edge; decide what comes next
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        op = pending_ops.pop_front();
        in_valid <= 1'b1;
        kind     <= op.op_kind;
        value    <= op.op_value;
        send_gap = send_burst ? 0 : pick_gap();
        if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, burst stretches, and one long hold-off once a
  // number of results have come, so the block backs up and drops in_ready.
  // ---------------------------------------------------------------------------
  int unsigned results_seen   = 0;
  int unsigned recv_stall     = 0;
  logic        recv_burst     = 1'b0;
  logic        long_hold_done = 1'b0;

  always @(posedge clk) begin : recv_side
    logic        rdy;
    int unsigned gap;
    rdy = 1'b1;
    if (rst) begin
      rdy = 1'b0;
    end else if (!long_hold_done && results_seen >= HOLD_AT) begin
      long_hold_done = 1'b1;
      recv_stall     = HOLD_CYCLES - 1;
      rdy            = 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      rdy = 1'b0;
    end else if (!recv_burst && $urandom_range(0, 99) < 25) begin
      gap = pick_gap();
      if (gap > 0) begin
        recv_stall = gap - 1;
        rdy        = 1'b0;
      end
    end
    if ($urandom_range(0, 199) == 0) recv_burst = !recv_burst;
    out_ready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input beat, check every result beat
  // against the oldest prediction, field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_side
    heap_report_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        expected_reports.push_back(heap_apply(kind, value));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_reports.size() == 0) begin
          $error("result beat with no operation outstanding");
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (top_value !== want.top) begin
            $error("top_value: expected %0d, got %0d", want.top, top_value);
            fail_count++;
          end
          if (is_empty !== want.empty) begin
            $error("is_empty: expected %0d, got %0d", want.empty, is_empty);
            fail_count++;
          end
          if (count !== want.cnt) begin
            $error("count: expected %0d, got %0d", want.cnt, count);
            fail_count++;
          end
          if (error !== want.err) begin
            $error("error: expected %0d, got %0d", want.err, error);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: no beat on either side for too long means the block hung.
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the whole stimulus list, release reset, wait for drain.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned k;

    // directed: pop on empty, field extremes, duplicates, drain past empty
    queue_op(KIND_POP,  32'sh1234_5678);
    queue_op(KIND_PUSH, '0);
    queue_op(KIND_PUSH, 32'sh7FFF_FFFF);
    queue_op(KIND_PUSH, 32'sh8000_0000);
    queue_op(KIND_PUSH, -1);
    queue_op(KIND_PUSH, 1);
    queue_op(KIND_PUSH, 32'sh8000_0000);
    queue_op(KIND_PUSH, 32'sh7FFF_FFFF);
    for (k = 0; k < 7; k++)
      queue_op(KIND_POP, $urandom);
    queue_op(KIND_POP, 32'shFFFF_FFFF);
    // descending pushes walk the new value all the way to the root
    for (k = 5; k >= 1; k--)
      queue_op(KIND_PUSH, k);
    queue_op(KIND_POP, '0);
    queue_op(KIND_POP, '0);

    // random, low occupancy: empty-heap pops come up often
    for (k = 0; k < 300; k++)
      queue_random(50);
    // fill to capacity
    while (gen_size < HEAP_DEPTH)
      queue_random(88);
    // linger at the top: pushes on a full heap
    for (k = 0; k < 40; k++)
      queue_random(70);
    // drain for the rest of the run
    k = 0;
    while (pending_ops.size() < RANDOM_TOTAL || k < 100) begin
      queue_random(20);
      k++;
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_ops.size() > 0 || in_valid)
      @(negedge clk);
    while (expected_reports.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d pushes and %0d pops, heap peak %0d of %0d entries",
             push_total, pop_total, peak_size, HEAP_DEPTH);
    $display("%0d pops on an empty heap, %0d pushes on a full heap, %0d mismatches",
             empty_pops, full_pushes, fail_count);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/mhpq_pkg.sv
rtl/mhpq_ctrl.sv
rtl/mhpq_dp.sv
rtl/min_heap_priority_queue_top.sv
dv/min_heap_priority_queue_top_tb.sv
